### rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// KMP matcher package
// Shared constants, types and helper functions of the streaming matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

   localparam int PATTERN_MAX_DEF   = 8;
   localparam int POSITION_BITS_DEF = 32;

   localparam int TEXT_BITS      = 8;
   localparam int START_BITS     = 32;
   localparam int PAT_BYTES      = 8;
   localparam int PAT_BITS       = 8 * PAT_BYTES;
   localparam int PAT_SEL_BITS   = 3;
   localparam int LENGTH_BITS    = 4;
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = PAT_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_BYTES  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 4'd1;

   typedef enum logic [1:0] {
      ST_DERIVE,
      ST_IDLE,
      ST_SCAN
   } kmp_state_type;

   typedef struct packed {
      logic req_ready;
      logic item_load;
      logic fallback;
      logic finish;
      logic derive_clear;
      logic derive_write;
   } kmp_cmd_type;

   typedef struct packed {
      logic cfg_hit;
      logic derive_last;
      logic mismatch;
      logic rsp_free;
   } kmp_status_type;

   function automatic logic [TEXT_BITS-1:0] pat_byte(input logic [PAT_BITS-1:0] pattern,
                                                     input logic [PAT_SEL_BITS-1:0] k);
      return pattern[TEXT_BITS*k +: TEXT_BITS];
   endfunction

   // Length of the longest proper prefix of the first n bytes that is also a suffix.
   function automatic logic [LENGTH_BITS-1:0] border_of(input logic [PAT_BITS-1:0] pattern,
                                                        input logic [LENGTH_BITS-1:0] n);
      logic [LENGTH_BITS-1:0]  best;
      logic                    hit;
      logic [PAT_SEL_BITS-1:0] k;
      best = '0;
      for (int l = 1; l < PAT_BYTES; l++) begin
         hit = (LENGTH_BITS'(l) < n);
         for (int i = 0; i < PAT_BYTES - 1; i++) begin
            k = PAT_SEL_BITS'(n - LENGTH_BITS'(l) + LENGTH_BITS'(i));
            if (i < l && pat_byte(pattern, PAT_SEL_BITS'(i)) != pat_byte(pattern, k)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            best = LENGTH_BITS'(l);
         end
      end
      return best;
   endfunction

endpackage

### rtl/core/kmp_if.sv
// ----------------------------------------------------------------------------
// KMP matcher channels
// Valid/ready channels for text bytes and for match results.
// ----------------------------------------------------------------------------
interface kmp_req_if;
   import kmp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TEXT_BITS-1:0] text_char;
   logic                 restart;

   modport source (output valid, output text_char, output restart, input ready);
   modport sink (input valid, input text_char, input restart, output ready);
endinterface

interface kmp_rsp_if;
   import kmp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  match_found;
   logic [START_BITS-1:0] match_start;

   modport source (output valid, output match_found, output match_start, input ready);
   modport sink (input valid, input match_found, input match_start, output ready);
endinterface

### rtl/core/kmp_controller.sv
// ----------------------------------------------------------------------------
// KMP matcher controller
// Sequences the failure table derivation and the per-byte matching steps.
// ----------------------------------------------------------------------------
module kmp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  kmp_pkg::kmp_status_type status,
   output kmp_pkg::kmp_cmd_type    cmd
);
   import kmp_pkg::*;

   kmp_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DERIVE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (status.cfg_hit) begin
         state_in = ST_DERIVE;
      end else begin
         case (state_ff)
            ST_DERIVE: begin
               if (status.derive_last) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_in = ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (!status.mismatch && status.rsp_free) begin
                  state_in = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_DERIVE;
            end
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      cmd.derive_clear = status.cfg_hit;
      case (state_ff)
         ST_DERIVE: begin
            cmd.derive_write = 1'b1;
         end
         ST_IDLE: begin
            cmd.req_ready = !status.cfg_hit;
            cmd.item_load = req_valid && !status.cfg_hit;
         end
         ST_SCAN: begin
            cmd.fallback = status.mismatch;
            cmd.finish   = !status.mismatch && status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/core/kmp_datapath.sv
// ----------------------------------------------------------------------------
// KMP matcher datapath
// Pattern registers, failure table, match state, position and result register.
// ----------------------------------------------------------------------------
module kmp_datapath #(
   parameter int PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kmp_pkg::kmp_cmd_type                 cmd,
   output kmp_pkg::kmp_status_type              status,
   input  logic [kmp_pkg::TEXT_BITS-1:0]        req_text_char,
   input  logic                                 req_restart,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_match_found,
   output logic [kmp_pkg::START_BITS-1:0]       rsp_match_start,
   input  logic                                 csr_we,
   input  logic [kmp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [kmp_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import kmp_pkg::*;

   localparam int LEN_BITS  = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int FAIL_MASK = (PATTERN_MAX - 1) % PATTERN_MAX;

   logic [PAT_BITS-1:0]      pattern_ff, pattern_in;
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [LEN_BITS-1:0]      tbl_ff [PATTERN_MAX];
   logic [LEN_BITS-1:0]      tbl_wr_in;
   logic [IDX_BITS-1:0]      cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]      matched_ff, matched_in;
   logic [LEN_BITS-1:0]      j_ff, j_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [TEXT_BITS-1:0]     char_ff, char_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [START_BITS-1:0]    start_ff, start_in;

   logic [LEN_BITS-1:0]      eff_len;
   logic [LEN_BITS-1:0]      j_adv;
   logic [LEN_BITS-1:0]      tbl_rd;
   logic [IDX_BITS-1:0]      tbl_addr;
   logic                     pat_eq;
   logic                     cfg_hit;
   logic                     mismatch;

   assign cfg_hit = csr_we && (csr_index == CSR_PATTERN_BYTES ||
                               csr_index == CSR_PATTERN_LENGTH);

   // A length of zero behaves as one and anything above the maximum as the maximum.
   always_comb begin
      if (length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (length_ff > LENGTH_BITS'(PATTERN_MAX)) begin
         eff_len = LEN_BITS'(PATTERN_MAX);
      end else begin
         eff_len = LEN_BITS'(length_ff);
      end
   end

   assign pat_eq   = (char_ff == pat_byte(pattern_ff, PAT_SEL_BITS'(j_ff)));
   assign mismatch = (j_ff != '0) && !pat_eq;
   assign j_adv    = pat_eq ? LEN_BITS'(j_ff + LEN_BITS'(1)) : j_ff;

   assign tbl_addr = mismatch ? IDX_BITS'((j_ff - LEN_BITS'(1)) & LEN_BITS'(FAIL_MASK))
                              : IDX_BITS'(eff_len - LEN_BITS'(1));
   assign tbl_rd    = tbl_ff[tbl_addr];
   assign tbl_wr_in = LEN_BITS'(border_of(pattern_ff, LENGTH_BITS'(cnt_ff) + LENGTH_BITS'(1)));

   always_comb begin
      pattern_in   = pattern_ff;
      length_in    = length_ff;
      cnt_in       = cnt_ff;
      matched_in   = matched_ff;
      j_in         = j_ff;
      pos_in       = pos_ff;
      char_in      = char_ff;
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      start_in     = start_ff;

      if (csr_we && csr_index == CSR_PATTERN_BYTES) begin
         pattern_in = csr_wdata;
      end
      if (csr_we && csr_index == CSR_PATTERN_LENGTH) begin
         length_in = csr_wdata[LENGTH_BITS-1:0];
      end

      if (cmd.derive_clear) begin
         cnt_in = '0;
      end else if (cmd.derive_write) begin
         cnt_in = IDX_BITS'(cnt_ff + IDX_BITS'(1));
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.item_load) begin
         char_in = req_text_char;
         if (req_restart || matched_ff >= eff_len) begin
            j_in = '0;
         end else begin
            j_in = matched_ff;
         end
         if (req_restart) begin
            pos_in = '0;
         end
      end

      if (cmd.fallback) begin
         j_in = tbl_rd;
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         pos_in       = pos_ff + POSITION_BITS'(1);
         if (j_adv == eff_len) begin
            found_in   = 1'b1;
            start_in   = START_BITS'(pos_ff - POSITION_BITS'(eff_len) + POSITION_BITS'(1));
            matched_in = tbl_rd;
         end else begin
            found_in   = 1'b0;
            start_in   = '0;
            matched_in = j_adv;
         end
      end

      if (cfg_hit) begin
         matched_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= '0;
         length_ff    <= LENGTH_BITS'(1);
         cnt_ff       <= '0;
         matched_ff   <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         length_ff    <= length_in;
         cnt_ff       <= cnt_in;
         matched_ff   <= matched_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      char_ff  <= char_in;
      found_ff <= found_in;
      start_ff <= start_in;
      if (cmd.derive_write) begin
         tbl_ff[cnt_ff] <= tbl_wr_in;
      end
   end

   assign status.cfg_hit     = cfg_hit;
   assign status.derive_last = (cnt_ff == IDX_BITS'(PATTERN_MAX - 1));
   assign status.mismatch    = mismatch;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = found_ff;
   assign rsp_match_start = start_ff;

endmodule

### rtl/core/kmp_pattern_matcher.sv
// ----------------------------------------------------------------------------
// KMP pattern matcher
// Streaming Knuth-Morris-Pratt search of a configured pattern in a byte text.
// ----------------------------------------------------------------------------
// Every accepted text byte yields one result transaction, which flags whether
// the pattern ends at that byte and, if so, the position where the match
// began; overlapping matches are reported. A taken byte is scanned with at
// most PATTERN_MAX - 1 fallbacks through the failure table, one per cycle as
// the table has a single read port; the result is written once the output
// register is free. The next byte is taken while a result still waits on the
// output register. After reset and after every write of the pattern or its
// length, the failure table is rebuilt one entry a cycle, and no byte is
// accepted until all PATTERN_MAX entries are written. A write clears the
// matched length but keeps the text position.
// ----------------------------------------------------------------------------
module kmp_pattern_matcher #(
   parameter int PATTERN_MAX   = kmp_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   kmp_req_if.sink                             req_if,
   kmp_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [kmp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [kmp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import kmp_pkg::*;

   kmp_cmd_type    cmd;
   kmp_status_type status;

   kmp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .status    (status),
      .cmd       (cmd)
   );

   kmp_datapath #(
      .PATTERN_MAX   (PATTERN_MAX),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_text_char   (req_if.text_char),
      .req_restart     (req_if.restart),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_match_found (rsp_if.match_found),
      .rsp_match_start (rsp_if.match_start),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   assign req_if.ready = cmd.req_ready;

endmodule

### rtl/core/kmp_checker.sv
// ----------------------------------------------------------------------------
// KMP matcher checker
// Port-level assertions on the matcher, attached to the top level by bind.
// ----------------------------------------------------------------------------
module kmp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                match_found,
   input logic [kmp_pkg::START_BITS-1:0]      match_start,
   input logic                                csr_we,
   input logic [kmp_pkg::CSR_INDEX_BITS-1:0]  csr_index
);
   import kmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_found) && $stable(match_start))
      else $error("A stalled result transaction changed or was withdrawn.");

   a_no_match_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !match_found |-> match_start == '0)
      else $error("A result without a match carries a non-zero start position.");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A text transaction was accepted while the previous one was in work.");

   a_rebuild_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == CSR_PATTERN_BYTES || csr_index == CSR_PATTERN_LENGTH)
      |=> !req_ready)
      else $error("Text was accepted while the failure table was being rebuilt.");

   a_rebuild_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("Text was accepted before the failure table was built after reset.");

endmodule

bind kmp_pattern_matcher kmp_checker u_kmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .match_found (rsp_if.match_found),
   .match_start (rsp_if.match_start),
   .csr_we      (csr_we),
   .csr_index   (csr_index)
);

### test/testbench.sv
// ----------------------------------------------------------------------------
// KMP pattern matcher testbench
// Drives text bytes and register writes into the streaming matcher and checks
// every result transaction against the expected values of a short directed
// table or a behavioural model of the search kept inside the testbench. The
// table is followed by random phases, each with a fresh pattern drawn mostly
// from a small alphabet so that borders, fallbacks and overlaps occur often.
// ----------------------------------------------------------------------------
module testbench;
   import kmp_pkg::*;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_ITEMS    = 120;
   localparam int DIRECTED_ROWS  = 33;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LAST  = 4'd15;

   typedef struct packed {
      logic                  found;
      logic [START_BITS-1:0] start;
   } match_result_type;

   typedef enum bit {
      ROW_WRITE,
      ROW_TEXT
   } row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
      logic [TEXT_BITS-1:0]      text_char;
      logic                      restart;
      logic                      typed;
      logic                      found;
      logic [START_BITS-1:0]     start;
   } directed_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   kmp_req_if req_ch ();
   kmp_rsp_if rsp_ch ();

   kmp_pattern_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Search state as the block should hold it.
   logic [PAT_BITS-1:0]    pattern_word;
   logic [LENGTH_BITS-1:0] length_code;
   logic [LENGTH_BITS-1:0] matched_len;
   logic [START_BITS-1:0]  text_pos;
   logic [LENGTH_BITS-1:0] border_tab [PAT_BYTES];

   match_result_type pending_matches [$];
   match_result_type oldest_match;
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  rx_hold = 0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_TEXT,  4'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd2},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h00, 1'b1, 1'b1, 1'b1, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h00, 1'b0, 1'b1, 1'b1, 32'd1},
      '{ROW_WRITE, CSR_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd8, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b1, 1'b1, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b1, 1'b1, 32'd1},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_BYTES, 64'h0000_0062_6161_6261, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_PATTERN_LENGTH, 64'd5, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_UNUSED_FIRST, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_WRITE, CSR_UNUSED_LAST, 64'd0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b1, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h62, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h78, 1'b0, 1'b0, 1'b0, 32'd0},
      '{ROW_TEXT,  4'd0, 64'd0, 8'h61, 1'b1, 1'b0, 1'b0, 32'd0}
   };

   function automatic int unsigned active_length();
      if (length_code == 0) return 1;
      if (length_code > PAT_BYTES) return PAT_BYTES;
      return length_code;
   endfunction

   function automatic logic [TEXT_BITS-1:0] pattern_char(int unsigned k);
      return pattern_word[TEXT_BITS * (k % PAT_BYTES) +: TEXT_BITS];
   endfunction

   function automatic logic [LENGTH_BITS-1:0] longest_border(int unsigned n);
      int unsigned l;
      bit          same;
      for (l = n - 1; l >= 1; l--) begin
         same = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (pattern_char(i) != pattern_char(n - l + i)) same = 1'b0;
         end
         if (same) return LENGTH_BITS'(l);
      end
      return '0;
   endfunction

   function automatic void rebuild_borders();
      for (int i = 0; i < PAT_BYTES; i++) border_tab[i] = longest_border(i + 1);
      matched_len = '0;
   endfunction

   function automatic void apply_write(logic [CSR_INDEX_BITS-1:0] index,
                                       logic [CSR_DATA_BITS-1:0] data);
      case (index)
         CSR_PATTERN_BYTES: begin
            pattern_word = data;
            rebuild_borders();
         end
         CSR_PATTERN_LENGTH: begin
            length_code = data[LENGTH_BITS-1:0];
            rebuild_borders();
         end
         default: begin
         end
      endcase
   endfunction

   function automatic match_result_type scan_byte(logic [TEXT_BITS-1:0] value, logic fresh);
      int unsigned      len;
      int unsigned      j;
      match_result_type res;
      len = active_length();
      if (fresh) begin
         text_pos = '0;
         matched_len = '0;
      end
      j = matched_len;
      if (j >= len) j = 0;
      while (j > 0 && value != pattern_char(j)) j = border_tab[j - 1];
      if (value == pattern_char(j)) j++;
      res = '0;
      if (j == len) begin
         res.found = 1'b1;
         res.start = text_pos - START_BITS'(len) + 1'b1;
         j = border_tab[len - 1];
      end
      matched_len = LENGTH_BITS'(j);
      text_pos = text_pos + 1'b1;
      return res;
   endfunction

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t: result transaction with none expected, found %0d start %0d",
                     $time, rsp_ch.match_found, rsp_ch.match_start);
            mismatch_count++;
         end else begin
            oldest_match = pending_matches.pop_front();
            if (rsp_ch.match_found !== oldest_match.found) begin
               $display("%0t: match_found expected %0d, actual %0d",
                        $time, oldest_match.found, rsp_ch.match_found);
               mismatch_count++;
            end
            if (rsp_ch.match_start !== oldest_match.start) begin
               $display("%0t: match_start expected %0d, actual %0d",
                        $time, oldest_match.start, rsp_ch.match_start);
               mismatch_count++;
            end
         end
         rx_hold = rx_idle_on ? $urandom_range(0, 7) : 0;
      end
   end

   task automatic send_byte(input logic [TEXT_BITS-1:0] value, input logic fresh,
                            input logic typed, input match_result_type typed_result);
      int unsigned      gap;
      match_result_type predicted;
      gap = tx_idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.text_char <= value;
      req_ch.restart   <= fresh;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = scan_byte(value, fresh);
      pending_matches.push_back(typed ? typed_result : predicted);
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_matches.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      apply_write(index, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [TEXT_BITS-1:0]   symbols [3];
      logic [CSR_DATA_BITS-1:0] word;
      logic [LENGTH_BITS-1:0] new_length;
      int unsigned            symbol_count;
      int unsigned            burst;
      int unsigned            pick;
      int unsigned            sent;

      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.text_char = '0;
      req_ch.restart   = 1'b0;
      rsp_ch.ready     = 1'b0;

      pattern_word = '0;
      length_code  = 4'd1;
      text_pos     = '0;
      rebuild_borders();

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_WRITE) begin
            write_reg(directed_rows[r].index, directed_rows[r].data);
         end else begin
            send_byte(directed_rows[r].text_char, directed_rows[r].restart,
                      directed_rows[r].typed,
                      '{directed_rows[r].found, directed_rows[r].start});
         end
      end

      // Each phase mostly draws its pattern from a small alphabet, so that the
      // text, drawn mostly from it too, exercises fallbacks and overlaps.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         tx_idle_on   = ($urandom_range(0, 3) != 0);
         rx_idle_on   = ($urandom_range(0, 3) != 0);
         symbol_count = $urandom_range(1, 3);
         foreach (symbols[k]) symbols[k] = TEXT_BITS'($urandom_range(0, 255));
         for (int k = 0; k < PAT_BYTES; k++) begin
            word[TEXT_BITS * k +: TEXT_BITS] = symbols[$urandom_range(0, symbol_count - 1)];
         end
         if ($urandom_range(0, 5) == 0) word = {$urandom(), $urandom()};
         case ($urandom_range(0, 9))
            0: new_length = 4'd0;
            1: new_length = LENGTH_BITS'($urandom_range(9, 15));
            default: new_length = LENGTH_BITS'($urandom_range(1, 8));
         endcase
         if ($urandom_range(0, 1) == 0) begin
            write_reg(CSR_PATTERN_BYTES, word);
            write_reg(CSR_PATTERN_LENGTH, {$urandom(), 16'($urandom_range(0, 16'hFFFF)),
                                           12'h000, new_length});
         end else begin
            write_reg(CSR_PATTERN_LENGTH, {60'd0, new_length});
            write_reg(CSR_PATTERN_BYTES, word);
         end
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)),
                      {$urandom(), $urandom()});
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               burst = active_length();
               for (int k = 0; k < burst; k++) begin
                  send_byte(pattern_char(k), ($urandom_range(0, 49) == 0), 1'b0, '0);
               end
               sent += burst;
            end else if (pick < 9) begin
               send_byte(symbols[$urandom_range(0, symbol_count - 1)],
                         ($urandom_range(0, 49) == 0), 1'b0, '0);
               sent++;
            end else begin
               send_byte(TEXT_BITS'($urandom_range(0, 255)), ($urandom_range(0, 49) == 0),
                         1'b0, '0);
               sent++;
            end
            if ($urandom_range(0, 149) == 0) settle();
         end
      end

      settle();
      if (mismatch_count == 0 && pending_matches.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
